### sv/lir_pkg.sv
// Package: shared constants, types and controller command/status structs of the resampler.
`timescale 1ns / 1ps
package lir_pkg;

    localparam int MAX_RUN = 64;
    localparam int CNT_W   = 7;
    localparam int TIME_W  = 40;
    localparam int GRID_W  = 41;
    localparam int WIDE_W  = 42;
    localparam int POS_W   = 32;
    localparam int HDG_W   = 24;
    localparam int PER_W   = 32;
    localparam int DIFF_W  = 33;
    localparam int PROD_W  = 73;
    localparam int STEP_W  = 6;
    localparam int CFG_AW  = 2;
    localparam int CFG_DW  = 40;
    localparam int TDATA_W = 128;
    localparam int OUSER_W = 2;

    localparam logic [CFG_AW-1:0] REG_PERIOD = 2'd0;
    localparam logic [CFG_AW-1:0] REG_START  = 2'd1;
    localparam logic [CFG_AW-1:0] REG_END    = 2'd2;

    localparam logic [PER_W-1:0]  DEF_PERIOD = 32'd20000;
    localparam logic [1:0]        FIELD_LAST = 2'd2;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_SETUP,
        CS_MODW,
        CS_CHECK,
        CS_LSTART,
        CS_LWAIT,
        CS_EMIT,
        CS_FINISH
    } ctrl_state_t;

    typedef enum logic [1:0] {
        MD_IDLE,
        MD_MUL,
        MD_DIV
    } md_phase_t;

    typedef struct packed {
        logic load_item;
        logic setup;
        logic start_mod;
        logic load_final;
        logic start_lerp;
        logic store_lerp;
        logic emit;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic need_mod;
        logic want_point;
        logic need_lerp;
        logic md_done;
        logic field_last;
        logic out_free;
    } stat_t;

endpackage

### sv/lir_muldiv.sv
// Multi-cycle shift-add multiplier and restoring divider shared by interpolation and grid skip.
`timescale 1ns / 1ps
module lir_muldiv
    import lir_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic                mode_mod,   // 1: remainder of num / den only
    input  logic [TIME_W-1:0]   mul_a,
    input  logic [DIFF_W-1:0]   mul_b,
    input  logic [TIME_W-1:0]   num,
    input  logic [TIME_W-1:0]   den,
    output logic                done,
    output logic [DIFF_W-1:0]   quot,
    output logic [TIME_W-1:0]   rem
);

    md_phase_t           phase_reg, phase_next;
    logic [STEP_W-1:0]   cnt_reg, cnt_next;
    logic [PROD_W-1:0]   acc_reg, acc_next;
    logic [DIFF_W-1:0]   mb_reg, mb_next;
    logic [TIME_W-1:0]   ma_reg, ma_next;
    logic [TIME_W-1:0]   den_reg, den_next;
    logic [TIME_W-1:0]   rem_reg, rem_next;
    logic [DIFF_W-1:0]   quot_reg, quot_next;
    logic                done_reg, done_next;
    logic [PROD_W-1:0]   mul_sum;
    logic [TIME_W:0]     sh;
    logic                qbit;

    // One multiplier bit or one quotient bit per cycle.
    always_comb begin
        mul_sum    = {acc_reg[PROD_W-2:0], 1'b0} + (mb_reg[DIFF_W-1] ?
                     {{(PROD_W-TIME_W){1'b0}}, ma_reg} : '0);
        sh         = {rem_reg, acc_reg[PROD_W-1]};
        qbit       = sh >= {1'b0, den_reg};
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        mb_next    = mb_reg;
        ma_next    = ma_reg;
        den_next   = den_reg;
        rem_next   = rem_reg;
        quot_next  = quot_reg;
        done_next  = 1'b0;
        case (phase_reg)
            MD_IDLE: begin
                if (start) begin
                    den_next  = den;
                    quot_next = '0;
                    if (mode_mod) begin
                        acc_next   = {num, {(PROD_W-TIME_W){1'b0}}};
                        rem_next   = '0;
                        cnt_next   = STEP_W'(TIME_W - 1);
                        phase_next = MD_DIV;
                    end else begin
                        acc_next   = '0;
                        ma_next    = mul_a;
                        mb_next    = mul_b;
                        cnt_next   = STEP_W'(DIFF_W - 1);
                        phase_next = MD_MUL;
                    end
                end
            end
            MD_MUL: begin
                mb_next = {mb_reg[DIFF_W-2:0], 1'b0};
                if (cnt_reg == '0) begin
                    rem_next   = mul_sum[PROD_W-1:DIFF_W];
                    acc_next   = {mul_sum[DIFF_W-1:0], {(PROD_W-DIFF_W){1'b0}}};
                    cnt_next   = STEP_W'(DIFF_W - 1);
                    phase_next = MD_DIV;
                end else begin
                    acc_next = mul_sum;
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            MD_DIV: begin
                rem_next  = qbit ? TIME_W'(sh - {1'b0, den_reg}) : sh[TIME_W-1:0];
                acc_next  = {acc_reg[PROD_W-2:0], 1'b0};
                quot_next = {quot_reg[DIFF_W-2:0], qbit};
                if (cnt_reg == '0) begin
                    phase_next = MD_IDLE;
                    done_next  = 1'b1;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            default: phase_next = MD_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= MD_IDLE;
            done_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
        cnt_reg  <= cnt_next;
        acc_reg  <= acc_next;
        mb_reg   <= mb_next;
        ma_reg   <= ma_next;
        den_reg  <= den_next;
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;
    assign rem  = rem_reg;

endmodule

### sv/lir_ctrl.sv
// Controller state machine sequencing setup, grid skip, interpolation and output words.
`timescale 1ns / 1ps
module lir_ctrl
    import lir_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_tvalid,
    output logic  s_tready,
    input  stat_t st,
    output cmd_t  cmd
);

    ctrl_state_t state_reg, state_next;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            CS_IDLE:   if (s_tvalid) state_next = CS_SETUP;
            CS_SETUP:  state_next = st.need_mod ? CS_MODW : CS_CHECK;
            CS_MODW:   if (st.md_done) state_next = CS_CHECK;
            CS_CHECK: begin
                if (!st.want_point) begin
                    state_next = CS_FINISH;
                end else if (st.need_lerp) begin
                    state_next = CS_LSTART;
                end else begin
                    state_next = CS_EMIT;
                end
            end
            CS_LSTART: state_next = CS_LWAIT;
            CS_LWAIT: begin
                if (st.md_done) state_next = st.field_last ? CS_EMIT : CS_LSTART;
            end
            CS_EMIT:   if (st.out_free) state_next = CS_CHECK;
            CS_FINISH: state_next = CS_IDLE;
            default:   state_next = CS_IDLE;
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            CS_IDLE: begin
                s_tready      = 1'b1;
                cmd.load_item = s_tvalid;
            end
            CS_SETUP: begin
                cmd.setup     = 1'b1;
                cmd.start_mod = st.need_mod;
            end
            CS_MODW:   cmd.load_final = st.md_done;
            CS_LSTART: cmd.start_lerp = 1'b1;
            CS_LWAIT:  cmd.store_lerp = st.md_done;
            CS_EMIT:   cmd.emit       = st.out_free;
            CS_FINISH: cmd.finish     = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CS_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### sv/lir_dpath.sv
// Datapath: configuration, stored sample, grid position, interpolation and output register.
`timescale 1ns / 1ps
module lir_dpath
    import lir_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [CFG_AW-1:0]   cfg_addr,
    input  logic [CFG_DW-1:0]   cfg_wdata,
    input  logic                in_kind,
    input  logic [TIME_W-1:0]   in_time,
    input  logic [POS_W-1:0]    in_x,
    input  logic [POS_W-1:0]    in_y,
    input  logic [HDG_W-1:0]    in_hdg,
    input  cmd_t                cmd,
    output stat_t               st,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [TDATA_W-1:0]  m_tdata,
    output logic                m_tlast,
    output logic [OUSER_W-1:0]  m_tuser
);

    // Configuration registers.
    logic [PER_W-1:0]  period_reg;
    logic [TIME_W-1:0] start_reg, end_reg;

    // Current item and stored sample.
    logic              kind_reg;
    logic [TIME_W-1:0] t1_reg;
    logic [POS_W-1:0]  cx_reg, cy_reg;
    logic [HDG_W-1:0]  ch_reg;
    logic              pvalid_reg;
    logic [TIME_W-1:0] ptime_reg;
    logic [POS_W-1:0]  px_reg, py_reg;
    logic [HDG_W-1:0]  ph_reg;
    logic [GRID_W-1:0] grid_reg, final_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              ovf_reg;
    logic [1:0]        field_reg;
    logic [POS_W-1:0]  lx_reg, ly_reg;
    logic [HDG_W-1:0]  lh_reg;

    // Output register.
    logic              ovalid_reg;
    logic [TDATA_W-1:0] odata_reg;
    logic              olast_reg;
    logic [OUSER_W-1:0] ouser_reg;

    logic [WIDE_W-1:0] g64;
    logic              ovf_now;
    logic [GRID_W-1:0] grid_inc, done_grid;
    logic              more;
    logic              is_last;
    logic [DIFF_W-1:0] fa, fb, fd, mag;
    logic              neg;
    logic [TIME_W-1:0] dt, span;
    logic              md_done;
    logic [DIFF_W-1:0] md_quot;
    logic [TIME_W-1:0] md_rem;
    logic [DIFF_W-1:0] qr, lres;
    logic [TIME_W-1:0] mod_num;
    logic [PER_W-1:0]  r32;
    logic [POS_W-1:0]  ex, ey;
    logic [HDG_W-1:0]  eh;
    logic [TIME_W-1:0] raw_off;

    assign raw_off = (in_time > start_reg) ? in_time - start_reg : '0;

    // Overflow is known at setup: the point after MAX_RUN more periods must still be due.
    assign g64     = {1'b0, grid_reg} + ({{(WIDE_W-PER_W){1'b0}}, period_reg}
                     * WIDE_W'(MAX_RUN));
    assign ovf_now = kind_reg ? (pvalid_reg && g64 <= {2'b0, end_reg})
                              : (g64 <= {2'b0, end_reg} && g64 < {2'b0, t1_reg});
    assign mod_num = t1_reg - g64[TIME_W-1:0];
    assign r32     = md_rem[PER_W-1:0];

    // Loop condition for the current grid point and for the one after it.
    assign grid_inc = grid_reg + {{(GRID_W-PER_W){1'b0}}, period_reg};
    assign more     = (grid_inc <= {1'b0, end_reg})
                      && (kind_reg || grid_inc < {1'b0, t1_reg});
    assign is_last  = (cnt_reg == CNT_W'(MAX_RUN - 1)) || !more;
    assign done_grid = (ovf_reg && !kind_reg && cnt_reg == CNT_W'(MAX_RUN - 1))
                       ? final_reg : grid_inc;

    always_comb begin
        st            = '0;
        st.need_mod   = !kind_reg && ovf_now;
        st.want_point = (cnt_reg < CNT_W'(MAX_RUN)) && (grid_reg <= {1'b0, end_reg})
                        && (kind_reg ? pvalid_reg : grid_reg < {1'b0, t1_reg});
        st.need_lerp  = !kind_reg && pvalid_reg && grid_reg >= {1'b0, ptime_reg};
        st.md_done    = md_done;
        st.field_last = field_reg == FIELD_LAST;
        st.out_free   = !ovalid_reg || m_tready;
    end

    // Operands of the field being interpolated.
    always_comb begin
        case (field_reg)
            2'd0:    begin fa = DIFF_W'(signed'(px_reg)); fb = DIFF_W'(signed'(cx_reg)); end
            2'd1:    begin fa = DIFF_W'(signed'(py_reg)); fb = DIFF_W'(signed'(cy_reg)); end
            default: begin fa = DIFF_W'(signed'(ph_reg)); fb = DIFF_W'(signed'(ch_reg)); end
        endcase
        fd   = fb - fa;
        neg  = fd[DIFF_W-1];
        mag  = neg ? DIFF_W'(-fd) : fd;
        dt   = grid_reg[TIME_W-1:0] - ptime_reg;
        span = t1_reg - ptime_reg;
        qr   = md_quot + {{(DIFF_W-1){1'b0}}, ({md_rem, 1'b0} >= {1'b0, span})};
        lres = neg ? fa - qr : fa + qr;
    end

    lir_muldiv u_md (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.start_mod | cmd.start_lerp),
        .mode_mod (cmd.start_mod),
        .mul_a    (dt),
        .mul_b    (mag),
        .num      (mod_num),
        .den      (cmd.start_mod ? {{(TIME_W-PER_W){1'b0}}, period_reg} : span),
        .done     (md_done),
        .quot     (md_quot),
        .rem      (md_rem)
    );

    // Values of the word to emit.
    always_comb begin
        if (st.need_lerp) begin
            ex = lx_reg; ey = ly_reg; eh = lh_reg;
        end else if (kind_reg || (pvalid_reg && grid_reg < {1'b0, ptime_reg})) begin
            ex = px_reg; ey = py_reg; eh = ph_reg;
        end else begin
            ex = cx_reg; ey = cy_reg; eh = ch_reg;
        end
    end

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg <= DEF_PERIOD;
            start_reg  <= '0;
            end_reg    <= '1;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_PERIOD: period_reg <= (cfg_wdata[PER_W-1:0] == '0) ? PER_W'(1)
                                                                      : cfg_wdata[PER_W-1:0];
                REG_START:  start_reg  <= cfg_wdata[TIME_W-1:0];
                REG_END:    end_reg    <= cfg_wdata[TIME_W-1:0];
                default: ;
            endcase
        end
    end

    // Item, sample and grid state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pvalid_reg <= 1'b0;
            ptime_reg  <= '0;
            px_reg     <= '0;
            py_reg     <= '0;
            ph_reg     <= '0;
            grid_reg   <= '0;
            cnt_reg    <= '0;
            ovf_reg    <= 1'b0;
            field_reg  <= '0;
        end else begin
            if (cmd.setup) begin
                cnt_reg   <= '0;
                ovf_reg   <= ovf_now;
                field_reg <= '0;
            end
            if (cmd.load_final) begin
                final_reg <= {1'b0, t1_reg} + ((r32 == '0) ? '0
                             : {{(GRID_W-PER_W){1'b0}}, period_reg - r32});
            end
            if (cmd.store_lerp) begin
                case (field_reg)
                    2'd0:    lx_reg <= lres[POS_W-1:0];
                    2'd1:    ly_reg <= lres[POS_W-1:0];
                    default: lh_reg <= lres[HDG_W-1:0];
                endcase
                field_reg <= (field_reg == FIELD_LAST) ? 2'd0 : field_reg + 2'd1;
            end
            if (cmd.emit) begin
                grid_reg <= grid_inc;
                cnt_reg  <= cnt_reg + 1'b1;
            end
            if (cmd.finish && !kind_reg) begin
                pvalid_reg <= 1'b1;
                ptime_reg  <= t1_reg;
                px_reg     <= cx_reg;
                py_reg     <= cy_reg;
                ph_reg     <= ch_reg;
                if (ovf_reg) grid_reg <= final_reg;
            end
        end
        if (cmd.load_item) begin
            kind_reg <= in_kind;
            t1_reg   <= raw_off;
            cx_reg   <= in_x;
            cy_reg   <= in_y;
            ch_reg   <= in_hdg;
        end
    end

    // Output register: refilled when the receiver takes the word.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ovalid_reg <= 1'b0;
        end else if (cmd.emit) begin
            ovalid_reg <= 1'b1;
        end else if (m_tready) begin
            ovalid_reg <= 1'b0;
        end
        if (cmd.emit) begin
            odata_reg <= {eh, ey, ex, grid_reg[TIME_W-1:0]};
            olast_reg <= is_last;
            ouser_reg <= {ovf_reg, done_grid > {1'b0, end_reg}};
        end
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = odata_reg;
    assign m_tlast  = olast_reg;
    assign m_tuser  = ouser_reg;

endmodule

### sv/linear_interp_resampler_core.sv
// Top level of the linear interpolation resampler for pose samples.
//
// Input words carry a pose sample (or a flush with tuser high); each
// accepted word causes up to 64 output words, one per grid point, with the
// last of them marked by m_tlast. Configuration is written through cfg_we,
// cfg_addr and cfg_wdata; the user must do so only while the block is idle,
// which the block itself does not enforce. An input word passes through
// accept, setup, final check and finish, plus a remainder pass through
// the multiply and divide unit when a long gap has to be skipped. Each
// grid point between two samples takes three passes through the shared
// bit-serial multiply and divide unit, one per coordinate, plus a check
// and an emit state; held points take the check and emit alone. The next
// input word is accepted after the final check and finish that follow the
// previous word's last result entering the output register. A stalled
// receiver holds the output word and stops the work at the next grid point.
// Reset (synchronous, active low) loads the default configuration, clears
// the stored sample and restarts the grid at zero.
`timescale 1ns / 1ps
module linear_interp_resampler_core
    import lir_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [CFG_AW-1:0]   cfg_addr,
    input  logic [CFG_DW-1:0]   cfg_wdata,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [TDATA_W-1:0]  s_tdata,   // sample_time, pos_x, pos_y, heading
    input  logic                s_tuser,   // kind
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [TDATA_W-1:0]  m_tdata,   // grid_time, out_x, out_y, out_heading
    output logic                m_tlast,
    output logic [OUSER_W-1:0]  m_tuser    // grid_done, overflow
);

    cmd_t  cmd;
    stat_t st;

    lir_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    lir_dpath u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_kind   (s_tuser),
        .in_time   (s_tdata[39:0]),
        .in_x      (s_tdata[71:40]),
        .in_y      (s_tdata[103:72]),
        .in_hdg    (s_tdata[127:104]),
        .cmd       (cmd),
        .st        (st),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule
